/* hdl/tdpt_pkg.sv */
// ----------------------------------------------------------------------------
// tdpt_pkg: shared types and constants of the trial division prime test
// Holds the operand width, stream widths, divisor constants and the command
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    // Width of the tested value and the derived stream widths.
    localparam int VALUE_WIDTH = 32;
    localparam int S_TDATA_W   = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W   = 8;
    localparam int CNT_W       = $clog2(VALUE_WIDTH);
    localparam int SQ_W        = 2 * VALUE_WIDTH;

    // Divisor sequence constants (6k-1 and 6k+1 pairs).
    localparam int FIRST_DIVISOR  = 5;
    localparam int DIVISOR_STRIDE = 6;
    localparam int PAIR_OFFSET    = 2;
    localparam int SMALL_PRIME    = 3;

    // Square increment when the divisor moves by the stride:
    // (d+6)^2 - d^2 = 12*d + 36.
    localparam int SQ_STEP_CONST = DIVISOR_STRIDE * DIVISOR_STRIDE;

    // Which divisor the remainder unit is started with.
    typedef enum logic [1:0] {
        DIV_SEL_THREE,
        DIV_SEL_D,
        DIV_SEL_D_PAIR
    } div_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;       // capture a new value
        logic     div_start;  // start one remainder computation
        div_sel_t div_sel;    // divisor for that computation
        logic     init_d;     // set the trial divisor to its first value
        logic     step_d;     // advance the trial divisor by the stride
    } tdpt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic le_one;     // value is 0 or 1
        logic le_three;   // value is at most 3
        logic even;       // value is a multiple of 2
        logic div_done;   // remainder is ready (one-cycle pulse)
        logic rem_zero;   // last remainder is zero
        logic sq_gt_n;    // divisor squared exceeds the value
    } tdpt_status_t;

endpackage

/* hdl/tdpt_datapath.sv */
// ----------------------------------------------------------------------------
// tdpt_datapath: operand, trial divisor and remainder unit
// Holds the value under test, the running divisor and its square, and a
// restoring remainder unit that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdpt_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [tdpt_pkg::VALUE_WIDTH-1:0]    value,
    input  tdpt_pkg::tdpt_cmd_t                 cmd,
    output tdpt_pkg::tdpt_status_t              status
);
    import tdpt_pkg::*;

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(VALUE_WIDTH - 1);

    logic [VALUE_WIDTH-1:0] n_reg;
    logic [VALUE_WIDTH-1:0] d_reg;
    logic [SQ_W-1:0]        sq_reg;
    logic [VALUE_WIDTH-1:0] div_reg;
    logic [VALUE_WIDTH-1:0] rem_reg;
    logic [VALUE_WIDTH-1:0] rem_next;
    logic [VALUE_WIDTH-1:0] shift_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   diff;
    logic [VALUE_WIDTH-1:0] sel_div;
    logic [SQ_W-1:0]        d_wide;

    // Divisor selection for a new remainder computation.
    always_comb begin
        unique case (cmd.div_sel)
            DIV_SEL_THREE:  sel_div = VALUE_WIDTH'(SMALL_PRIME);
            DIV_SEL_D:      sel_div = d_reg;
            DIV_SEL_D_PAIR: sel_div = d_reg + VALUE_WIDTH'(PAIR_OFFSET);
            default:        sel_div = d_reg;
        endcase
    end

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        trial = {rem_reg, shift_reg[VALUE_WIDTH-1]};
        diff  = trial - {1'b0, div_reg};
        if (trial >= {1'b0, div_reg}) begin
            rem_next = diff[VALUE_WIDTH-1:0];
        end else begin
            rem_next = trial[VALUE_WIDTH-1:0];
        end
    end

    // Operand capture and the trial divisor with its running square.
    assign d_wide = SQ_W'(d_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            n_reg <= value;
        end
        if (cmd.init_d) begin
            d_reg  <= VALUE_WIDTH'(FIRST_DIVISOR);
            sq_reg <= SQ_W'(FIRST_DIVISOR * FIRST_DIVISOR);
        end else if (cmd.step_d) begin
            d_reg  <= d_reg + VALUE_WIDTH'(DIVISOR_STRIDE);
            sq_reg <= sq_reg + (d_wide << 3) + (d_wide << 2) + SQ_W'(SQ_STEP_CONST);
        end
    end

    // Remainder unit payload.
    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            div_reg   <= sel_div;
            rem_reg   <= '0;
            shift_reg <= n_reg;
            cnt_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg   <= rem_next;
            shift_reg <= {shift_reg[VALUE_WIDTH-2:0], 1'b0};
            cnt_reg   <= cnt_reg + 1'b1;
        end
    end

    // Remainder unit control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == LAST_CNT);
            if (cmd.div_start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (cnt_reg == LAST_CNT)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Status toward the controller.
    assign status.le_one   = (n_reg <= VALUE_WIDTH'(1));
    assign status.le_three = (n_reg <= VALUE_WIDTH'(SMALL_PRIME));
    assign status.even     = ~n_reg[0];
    assign status.div_done = done_reg;
    assign status.rem_zero = (rem_reg == '0);
    assign status.sq_gt_n  = (sq_reg > SQ_W'(n_reg));

endmodule

/* hdl/tdpt_ctrl.sv */
// ----------------------------------------------------------------------------
// tdpt_ctrl: sequencer of the trial division prime test
// Walks through the small-value checks, the division by three and the
// 6k-1 / 6k+1 divisor loop, and owns the registered result channel.
// ----------------------------------------------------------------------------
module tdpt_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic                    is_prime,
    output tdpt_pkg::tdpt_cmd_t     cmd,
    input  tdpt_pkg::tdpt_status_t  status
);
    import tdpt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WAIT3,
        ST_TEST,
        ST_WAITA,
        ST_WAITB,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   verdict_reg;
    logic   verdict_next;
    logic   m_valid_reg;
    logic   result_reg;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign is_prime = result_reg;
    assign out_free = !m_valid_reg || m_tready;

    // Next state, verdict and datapath commands.
    always_comb begin
        state_next    = state_reg;
        verdict_next  = verdict_reg;
        cmd.load      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_sel   = DIV_SEL_THREE;
        cmd.init_d    = 1'b0;
        cmd.step_d    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                priority if (status.le_one) begin
                    verdict_next = 1'b0;
                    state_next   = ST_FINISH;
                end else if (status.le_three) begin
                    verdict_next = 1'b1;
                    state_next   = ST_FINISH;
                end else if (status.even) begin
                    verdict_next = 1'b0;
                    state_next   = ST_FINISH;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SEL_THREE;
                    state_next    = ST_WAIT3;
                end
            end
            ST_WAIT3: begin
                if (status.div_done) begin
                    if (status.rem_zero) begin
                        verdict_next = 1'b0;
                        state_next   = ST_FINISH;
                    end else begin
                        cmd.init_d = 1'b1;
                        state_next = ST_TEST;
                    end
                end
            end
            ST_TEST: begin
                if (status.sq_gt_n) begin
                    verdict_next = 1'b1;
                    state_next   = ST_FINISH;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SEL_D;
                    state_next    = ST_WAITA;
                end
            end
            ST_WAITA: begin
                if (status.div_done) begin
                    if (status.rem_zero) begin
                        verdict_next = 1'b0;
                        state_next   = ST_FINISH;
                    end else begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = DIV_SEL_D_PAIR;
                        state_next    = ST_WAITB;
                    end
                end
            end
            ST_WAITB: begin
                if (status.div_done) begin
                    if (status.rem_zero) begin
                        verdict_next = 1'b0;
                        state_next   = ST_FINISH;
                    end else begin
                        cmd.step_d = 1'b1;
                        state_next = ST_TEST;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and the registered result channel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            verdict_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            result_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            verdict_reg <= verdict_next;
            if (state_reg == ST_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
                result_reg  <= verdict_reg;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* hdl/trial_division_prime_test.sv */
// ----------------------------------------------------------------------------
// trial_division_prime_test: primality test by 6k-1 / 6k+1 trial division
// Top level joining the sequencer and the datapath to the stream ports.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one 32-bit unsigned value per transfer; the master
// channel returns one transfer per value with is_prime in bit 0 of m_tdata.
// Values 0 and 1 report 0, 2 and 3 report 1, and other even values report 0
// without a division. Odd values are divided by 3 and then by the pairs
// d, d+2 for d = 5, 11, 17, ... while d*d <= value.
// Each remainder comes from a restoring unit with one quotient bit per cycle;
// a 32-bit prime needs up to about 10,900 divisor pairs, and the remainder
// unit sets the run time.
// One value is worked on at a time: s_tready is high only while the block is
// idle. The result sits in an output register, so a new value is taken while
// an earlier result waits for m_tready; a finished result that finds the
// register still full waits until the receiver takes it.
// Synchronous active-low reset returns the block to idle and drops m_tvalid.
// ----------------------------------------------------------------------------
module trial_division_prime_test (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: value [31:0]
    input  logic [tdpt_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // m_tdata: is_prime [0], zeros [7:1]
    output logic [tdpt_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready
);
    import tdpt_pkg::*;

    tdpt_cmd_t    cmd;
    tdpt_status_t status;
    logic         is_prime;

    // Sequencer with the result register.
    tdpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .is_prime (is_prime),
        .cmd      (cmd),
        .status   (status)
    );

    // Operand, divisor and remainder unit.
    tdpt_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .value   (s_tdata[VALUE_WIDTH-1:0]),
        .cmd     (cmd),
        .status  (status)
    );

    // Result packing with zero fill to a whole byte.
    assign m_tdata = {{(M_TDATA_W-1){1'b0}}, is_prime};

endmodule

/* hdl/tdpt_checker.sv */
// ----------------------------------------------------------------------------
// tdpt_checker: port-level checks of the trial division prime test
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module tdpt_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [tdpt_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [tdpt_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready
);
    import tdpt_pkg::*;

    // Reset leaves no result pending.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // The padding bits of the result are always zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:1] == '0))
        else $error("nonzero padding in m_tdata");

    // A stalled result keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // After a transfer in, the block is busy with that value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("new value taken while busy");

    // No result can appear in the cycle right after a value is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

endmodule

bind trial_division_prime_test tdpt_checker u_tdpt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

/* test/prime_verdict_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_verdict_monitor: result checker for the trial division prime test
// Watches both stream channels, works out the expected primality verdict for
// every accepted value and compares each returned transfer against the
// oldest outstanding verdict.
// ----------------------------------------------------------------------------
module prime_verdict_monitor (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: value [31:0]
    input  logic [tdpt_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    // m_tdata: is_prime [0], zeros [7:1]
    input  logic [tdpt_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    output int                                mismatch_count,
    output int                                pending_verdicts
);

    import tdpt_pkg::*;

    logic expected_verdicts[$];

    // Trial division over 6k-1 / 6k+1 divisors, in 64-bit arithmetic so the
    // loop bound d <= n / d never overflows.
    function automatic logic predict_primality(input logic [VALUE_WIDTH-1:0] value);
        logic [63:0] n;
        logic [63:0] d;
        n = 64'(value);
        if (n <= 64'd1)
            return 1'b0;
        if (n <= 64'(SMALL_PRIME))
            return 1'b1;
        if ((n % 64'd2) == 64'd0 || (n % 64'd3) == 64'd0)
            return 1'b0;
        for (d = 64'(FIRST_DIVISOR); d <= n / d; d += 64'(DIVISOR_STRIDE)) begin
            if ((n % d) == 64'd0 || (n % (d + 64'(PAIR_OFFSET))) == 64'd0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    initial begin
        mismatch_count   = 0;
        pending_verdicts = 0;
    end

    // Record a verdict for each input transfer and check each output transfer.
    always @(posedge aclk) begin
        logic want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                expected_verdicts.push_back(predict_primality(s_tdata[VALUE_WIDTH-1:0]));
            if (m_tvalid && m_tready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("result transfer with no value outstanding: m_tdata=%h", m_tdata);
                    mismatch_count = mismatch_count + 1;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (m_tdata[0] !== want) begin
                        $error("is_prime: expected %0d, actual %0d", want, m_tdata[0]);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (m_tdata[M_TDATA_W-1:1] !== '0) begin
                        $error("padding: expected 0, actual %h", m_tdata[M_TDATA_W-1:1]);
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end
        end
        pending_verdicts <= expected_verdicts.size();
    end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the trial division prime test
// Sends directed edge values and then random values, mostly small or with a
// small forced factor so the long trial division stays affordable. Both
// channels idle at random, and the receiver holds off once for a long
// stretch so the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module testbench;

    import tdpt_pkg::*;

    localparam int RANDOM_ITEMS   = 77;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int IDLE_PERCENT   = 18;

    logic                   aclk;
    logic                   aresetn;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    int                     mismatch_count;
    int                     pending_verdicts;
    int                     values_sent;
    int                     verdicts_taken;

    trial_division_prime_test u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    prime_verdict_monitor u_monitor (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tdata          (s_tdata),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .m_tdata          (m_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .mismatch_count   (mismatch_count),
        .pending_verdicts (pending_verdicts)
    );

    // 100 MHz clock.
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Offer one value and hold it until the transfer happens. Sender gaps are
    // skipped for a stretch in the middle of the random part.
    task automatic offer_value(input logic [VALUE_WIDTH-1:0] value);
        int gap;
        if ((values_sent < 40 || values_sent > 70)
            && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= S_TDATA_W'(value);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        values_sent++;
    endtask

    // Random value: mostly small ones (primes among them), tiny ones, and
    // full-width ones with a small forced factor so the search ends early.
    function automatic logic [VALUE_WIDTH-1:0] pick_random_value();
        int unsigned kind;
        int unsigned factor;
        logic [VALUE_WIDTH-1:0] wide;
        kind = $urandom_range(99);
        if (kind < 55)
            return VALUE_WIDTH'($urandom_range(0, 12000));
        if (kind < 65)
            return VALUE_WIDTH'($urandom_range(0, 15));
        factor = $urandom_range(2, 40);
        wide   = VALUE_WIDTH'($urandom);
        return wide - (wide % VALUE_WIDTH'(factor));
    endfunction

    // Receiver: random stalls, one long hold-off early on, and a window of
    // results taken without any stall.
    initial begin
        m_tready       = 1'b0;
        verdicts_taken = 0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (verdicts_taken == 3) begin
                m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
                do @(posedge aclk); while (!m_tvalid);
                verdicts_taken++;
            end else begin
                if (verdicts_taken >= 50 && verdicts_taken <= 80)
                    m_tready <= 1'b1;
                else
                    m_tready <= ($urandom_range(99) >= IDLE_PERCENT);
                @(posedge aclk);
                if (m_tvalid && m_tready)
                    verdicts_taken++;
            end
        end
    end

    // Stimulus and final verdict.
    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        values_sent = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Zero and one, the small primes, even and multiple-of-three values.
        offer_value(32'd0);
        offer_value(32'd1);
        offer_value(32'd2);
        offer_value(32'd3);
        offer_value(32'd4);
        offer_value(32'd5);
        offer_value(32'd6);
        offer_value(32'd7);
        offer_value(32'd9);
        // Squares and products right at the loop bound of either divisor.
        offer_value(32'd25);
        offer_value(32'd35);
        offer_value(32'd49);
        offer_value(32'd121);
        offer_value(32'd143);
        offer_value(32'd169);
        offer_value(32'd289);
        offer_value(32'd323);
        offer_value(32'd63001);
        offer_value(32'd65521);
        // Top of the range, and the largest prime that fits the field.
        offer_value(32'hFFFF_FFFF);
        offer_value(32'hFFFF_FFFE);
        offer_value(32'h8000_0000);
        offer_value(32'd4294967291);

        for (int i = 0; i < RANDOM_ITEMS; i++)
            offer_value(pick_random_value());
        s_tvalid <= 1'b0;

        // Let the count of the last transfer settle, drain the outstanding
        // verdicts, then wait while the ports stay quiet.
        @(posedge aclk);
        while (pending_verdicts != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: ends a run that hangs and reports a mismatch.
    initial begin
        #(64'd60_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
hdl/tdpt_pkg.sv
hdl/tdpt_datapath.sv
hdl/tdpt_ctrl.sv
hdl/trial_division_prime_test.sv
hdl/tdpt_checker.sv
test/prime_verdict_monitor.sv
test/testbench.sv
